// ----- rtl/core/npk_pkg.sv -----
// Shared types, codes and default constants of the NoC initiator packetizer.
// Used by every module under rtl/core; depends on nothing.
package npk_pkg;

   // Defaults for the top-level parameters.
   localparam int BYTES_PER_FLIT_DEF = 4;
   localparam int SESSION_SPAN_DEF   = 1024;
   localparam int REGION_COUNT_DEF   = 3;
   localparam int QUEUE_DEPTH_DEF    = 2;

   // Fixed field widths.
   localparam int REGION_MAX = 3;
   localparam int CMD_W      = 2;
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 8;
   localparam int NODE_W     = 4;
   localparam int TAG_W      = 14;
   localparam int SESSION_W  = 10;
   localparam int KIND_W     = 3;
   localparam int FLITS_W    = 7;
   localparam int BODY_W     = 6;
   localparam int MAX_BODY   = 62;
   localparam int PADDR_W    = 5;
   localparam int PDATA_W    = 32;
   localparam int TARGETS_W  = REGION_MAX * NODE_W;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

   // Flit kinds.
   localparam logic [KIND_W-1:0] KIND_HEAD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BODY = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TAIL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DATA = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ACK  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERR  = 3'd5;

   // Register indexes (byte address bits 4..2).
   localparam logic [2:0] REG_LOCAL_NODE     = 3'd0;
   localparam logic [2:0] REG_REGION0_BASE   = 3'd1;
   localparam logic [2:0] REG_REGION0_LIMIT  = 3'd2;
   localparam logic [2:0] REG_REGION1_BASE   = 3'd3;
   localparam logic [2:0] REG_REGION1_LIMIT  = 3'd4;
   localparam logic [2:0] REG_REGION2_BASE   = 3'd5;
   localparam logic [2:0] REG_REGION2_LIMIT  = 3'd6;
   localparam logic [2:0] REG_REGION_TARGETS = 3'd7;

   typedef struct packed {
      logic [NODE_W-1:0]                    local_node;
      logic [REGION_MAX-1:0][ADDR_W-1:0]    base;
      logic [REGION_MAX-1:0][ADDR_W-1:0]    limit;
      logic [TARGETS_W-1:0]                 targets;
   } csr_type;

   // One classified request. A HEAD kind stands for a multi-flit packet;
   // every other kind is a single flit whose remaining count equals total.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FLITS_W-1:0] total;
      logic [TAG_W-1:0]   tag;
      logic [NODE_W-1:0]  target;
   } desc_type;

endpackage

// ----- rtl/core/npk_csr.sv -----
// Configuration registers of the packetizer behind an APB-style port.
// Depends on npk_pkg for register indexes and the csr_type bundle.
module npk_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [npk_pkg::PADDR_W-1:0]  paddr,
   input  logic [npk_pkg::PDATA_W-1:0]  pwdata,
   output logic [npk_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready,
   output npk_pkg::csr_type             csr
);

   logic [npk_pkg::NODE_W-1:0]                              local_node_ff, local_node_in;
   logic [npk_pkg::REGION_MAX-1:0][npk_pkg::ADDR_W-1:0]     base_ff, base_in;
   logic [npk_pkg::REGION_MAX-1:0][npk_pkg::ADDR_W-1:0]     limit_ff, limit_in;
   logic [npk_pkg::TARGETS_W-1:0]                           targets_ff, targets_in;
   logic [2:0]                                              reg_index;
   logic                                                    wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      local_node_in = local_node_ff;
      base_in       = base_ff;
      limit_in      = limit_ff;
      targets_in    = targets_ff;
      if (wr_en) begin
         case (reg_index)
            npk_pkg::REG_LOCAL_NODE:     local_node_in = pwdata[npk_pkg::NODE_W-1:0];
            npk_pkg::REG_REGION0_BASE:   base_in[0]    = pwdata;
            npk_pkg::REG_REGION0_LIMIT:  limit_in[0]   = pwdata;
            npk_pkg::REG_REGION1_BASE:   base_in[1]    = pwdata;
            npk_pkg::REG_REGION1_LIMIT:  limit_in[1]   = pwdata;
            npk_pkg::REG_REGION2_BASE:   base_in[2]    = pwdata;
            npk_pkg::REG_REGION2_LIMIT:  limit_in[2]   = pwdata;
            npk_pkg::REG_REGION_TARGETS: targets_in    = pwdata[npk_pkg::TARGETS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_node_ff <= '0;
         base_ff       <= '1;
         limit_ff      <= '0;
         targets_ff    <= '0;
      end else begin
         local_node_ff <= local_node_in;
         base_ff       <= base_in;
         limit_ff      <= limit_in;
         targets_ff    <= targets_in;
      end
   end

   always_comb begin
      case (reg_index)
         npk_pkg::REG_LOCAL_NODE:     prdata = 32'(local_node_ff);
         npk_pkg::REG_REGION0_BASE:   prdata = base_ff[0];
         npk_pkg::REG_REGION0_LIMIT:  prdata = limit_ff[0];
         npk_pkg::REG_REGION1_BASE:   prdata = base_ff[1];
         npk_pkg::REG_REGION1_LIMIT:  prdata = limit_ff[1];
         npk_pkg::REG_REGION2_BASE:   prdata = base_ff[2];
         npk_pkg::REG_REGION2_LIMIT:  prdata = limit_ff[2];
         npk_pkg::REG_REGION_TARGETS: prdata = 32'(targets_ff);
         default:                     prdata = '0;
      endcase
   end

   assign csr.local_node = local_node_ff;
   assign csr.base       = base_ff;
   assign csr.limit      = limit_ff;
   assign csr.targets    = targets_ff;

endmodule

// ----- rtl/core/npk_front.sv -----
// Front end: accepts requests, routes them by address region, sizes the packet
// and assigns the session id. Depends on npk_pkg; feeds npk_queue.
module npk_front #(
   parameter int BYTES_PER_FLIT = npk_pkg::BYTES_PER_FLIT_DEF,
   parameter int SESSION_SPAN   = npk_pkg::SESSION_SPAN_DEF,
   parameter int REGION_COUNT   = npk_pkg::REGION_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  npk_pkg::csr_type             csr,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [npk_pkg::CMD_W-1:0]    req_command,
   input  logic [npk_pkg::ADDR_W-1:0]   req_address,
   input  logic [npk_pkg::LEN_W-1:0]    req_byte_length,
   input  logic [npk_pkg::NODE_W-1:0]   req_peer_node,
   input  logic [npk_pkg::TAG_W-1:0]    req_peer_session,
   input  logic                         full,
   output logic                         push,
   output npk_pkg::desc_type            push_desc
);

   // Ceiling division by a constant: (len + BPF - 1) * RECIP >> 16 is exact
   // for every rounded length below 512.
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + BYTES_PER_FLIT - 1) / BYTES_PER_FLIT;
   localparam int ROUND_W     = npk_pkg::LEN_W + 1;
   localparam int PROD_W      = ROUND_W + RECIP_SHIFT + 1;

   logic                             accept;
   logic                             hit;
   logic [npk_pkg::NODE_W-1:0]       dst;
   logic [ROUND_W-1:0]               round_len;
   logic [PROD_W-1:0]                prod;
   logic [ROUND_W-1:0]               quot;
   logic [npk_pkg::BODY_W-1:0]       body;
   logic [npk_pkg::SESSION_W:0]      cnt_sum;
   logic [npk_pkg::SESSION_W-1:0]    cnt_next;
   logic [npk_pkg::TAG_W:0]          tag_sum;
   logic [npk_pkg::SESSION_W-1:0]    session_ff, session_in;

   assign req_ready = !full;
   assign accept    = req_valid && !full;

   // Lowest-numbered matching region wins.
   always_comb begin
      hit = 1'b0;
      dst = '0;
      for (int i = npk_pkg::REGION_MAX - 1; i >= 0; i--) begin
         if (i < REGION_COUNT && csr.base[i] <= req_address &&
             req_address <= csr.limit[i]) begin
            hit = 1'b1;
            dst = csr.targets[i*npk_pkg::NODE_W +: npk_pkg::NODE_W];
         end
      end
   end

   assign round_len = ROUND_W'(req_byte_length) + ROUND_W'(BYTES_PER_FLIT - 1);
   assign prod      = PROD_W'(round_len) * PROD_W'(RECIP);
   assign quot      = prod[RECIP_SHIFT +: ROUND_W];

   always_comb begin
      if (req_command == npk_pkg::CMD_READ) begin
         body = npk_pkg::BODY_W'(1);
      end else if (quot > ROUND_W'(npk_pkg::MAX_BODY)) begin
         body = npk_pkg::BODY_W'(npk_pkg::MAX_BODY);
      end else begin
         body = quot[npk_pkg::BODY_W-1:0];
      end
   end

   // Wrap the session counter at the span; offset by the local node.
   assign cnt_sum  = {1'b0, session_ff} + 1'b1;
   assign cnt_next = (cnt_sum >= (npk_pkg::SESSION_W+1)'(SESSION_SPAN)) ?
                     '0 : cnt_sum[npk_pkg::SESSION_W-1:0];
   assign tag_sum  = (npk_pkg::TAG_W+1)'(cnt_next) +
                     (npk_pkg::TAG_W+1)'(int'(csr.local_node) * SESSION_SPAN);

   always_comb begin
      push       = 1'b0;
      push_desc  = '0;
      session_in = session_ff;
      case (req_command)
         npk_pkg::CMD_ACK: begin
            push             = accept;
            push_desc.kind   = npk_pkg::KIND_ACK;
            push_desc.total  = npk_pkg::FLITS_W'(1);
            push_desc.tag    = req_peer_session;
            push_desc.target = req_peer_node;
         end
         npk_pkg::CMD_READ, npk_pkg::CMD_WRITE: begin
            push = accept;
            if (!hit) begin
               push_desc.kind = npk_pkg::KIND_ERR;
            end else begin
               push_desc.tag    = tag_sum[npk_pkg::TAG_W-1:0];
               push_desc.target = dst;
               if (body == npk_pkg::BODY_W'(1)) begin
                  push_desc.kind  = npk_pkg::KIND_DATA;
                  push_desc.total = npk_pkg::FLITS_W'(1);
               end else begin
                  push_desc.kind  = npk_pkg::KIND_HEAD;
                  push_desc.total = npk_pkg::FLITS_W'(body) + npk_pkg::FLITS_W'(2);
               end
               if (accept) begin
                  session_in = cnt_next;
               end
            end
         end
         default: begin
            // drop: no flits, no state change
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff <= '1;
      end else begin
         session_ff <= session_in;
      end
   end

   // A zero-byte write is HEAD and TAIL only.
   a_head_size: assert property (@(posedge clock) disable iff (reset)
      (push && push_desc.kind == npk_pkg::KIND_HEAD) |->
      (push_desc.total >= npk_pkg::FLITS_W'(2) && push_desc.total <= npk_pkg::FLITS_W'(64)))
      else $error("multi-flit packet size out of range");

   a_drop_keeps_session: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == npk_pkg::CMD_NONE) |=> $stable(session_ff))
      else $error("dropped request changed the session counter");

endmodule

// ----- rtl/core/npk_queue.sv -----
// Short descriptor queue between the front and back ends of the packetizer.
// Depends on npk_pkg for desc_type.
module npk_queue #(
   parameter int DEPTH = npk_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  npk_pkg::desc_type   push_desc,
   output logic                full,
   input  logic                pop,
   output npk_pkg::desc_type   pop_desc,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   npk_pkg::desc_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

endmodule

// ----- rtl/core/npk_back.sv -----
// Back end: expands queued descriptors into flits, one per cycle while rsp_ready
// is high, through an output register. Depends on npk_pkg; reads from npk_queue.
module npk_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [npk_pkg::NODE_W-1:0]    local_node,
   input  npk_pkg::desc_type             pop_desc,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [npk_pkg::KIND_W-1:0]    rsp_flit_kind,
   output logic [npk_pkg::FLITS_W-1:0]   rsp_flits_remaining,
   output logic [npk_pkg::FLITS_W-1:0]   rsp_packet_flits,
   output logic [npk_pkg::TAG_W-1:0]     rsp_session_tag,
   output logic [npk_pkg::NODE_W-1:0]    rsp_source_node,
   output logic [npk_pkg::NODE_W-1:0]    rsp_target_node,
   output logic                          rsp_last_flit
);

   logic                           load;
   logic                           active_ff, active_in;
   logic [npk_pkg::FLITS_W-1:0]    rem_ff, rem_in;
   npk_pkg::desc_type              cur_ff, cur_in;
   logic                           valid_ff, valid_in;
   logic [npk_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [npk_pkg::FLITS_W-1:0]    remaining_ff, remaining_in;
   logic [npk_pkg::FLITS_W-1:0]    packet_ff, packet_in;
   logic [npk_pkg::TAG_W-1:0]      tag_ff, tag_in;
   logic [npk_pkg::NODE_W-1:0]     source_ff, source_in;
   logic [npk_pkg::NODE_W-1:0]     target_ff, target_in;
   logic                           last_ff, last_in;

   // Load the output register when it is empty or its transfer completes.
   assign load = !valid_ff || rsp_ready;

   always_comb begin
      pop          = 1'b0;
      active_in    = active_ff;
      rem_in       = rem_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      remaining_in = remaining_ff;
      packet_in    = packet_ff;
      tag_in       = tag_ff;
      source_in    = source_ff;
      target_in    = target_ff;
      last_in      = last_ff;
      if (load) begin
         if (active_ff) begin
            valid_in     = 1'b1;
            kind_in      = (rem_ff == npk_pkg::FLITS_W'(1)) ?
                           npk_pkg::KIND_TAIL : npk_pkg::KIND_BODY;
            remaining_in = rem_ff;
            packet_in    = cur_ff.total;
            tag_in       = cur_ff.tag;
            source_in    = local_node;
            target_in    = cur_ff.target;
            last_in      = (rem_ff == npk_pkg::FLITS_W'(1));
            rem_in       = rem_ff - 1'b1;
            active_in    = (rem_ff != npk_pkg::FLITS_W'(1));
         end else if (!empty) begin
            pop          = 1'b1;
            valid_in     = 1'b1;
            kind_in      = pop_desc.kind;
            remaining_in = pop_desc.total;
            packet_in    = pop_desc.total;
            tag_in       = pop_desc.tag;
            source_in    = local_node;
            target_in    = pop_desc.target;
            last_in      = (pop_desc.kind != npk_pkg::KIND_HEAD);
            cur_in       = pop_desc;
            rem_in       = pop_desc.total - 1'b1;
            active_in    = (pop_desc.kind == npk_pkg::KIND_HEAD);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
         rem_ff    <= '0;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
         rem_ff    <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      kind_ff      <= kind_in;
      remaining_ff <= remaining_in;
      packet_ff    <= packet_in;
      tag_ff       <= tag_in;
      source_ff    <= source_in;
      target_ff    <= target_in;
      last_ff      <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_flit_kind       = kind_ff;
   assign rsp_flits_remaining = remaining_ff;
   assign rsp_packet_flits    = packet_ff;
   assign rsp_session_tag     = tag_ff;
   assign rsp_source_node     = source_ff;
   assign rsp_target_node     = target_ff;
   assign rsp_last_flit       = last_ff;

   a_last_matches_count: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (last_ff == (remaining_ff <= npk_pkg::FLITS_W'(1))))
      else $error("last flag disagrees with remaining count");

   a_body_in_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == npk_pkg::KIND_BODY) |->
      (remaining_ff >= npk_pkg::FLITS_W'(2) && remaining_ff < packet_ff))
      else $error("body flit outside its packet");

endmodule

// ----- rtl/core/noc_initiator_packetizer.sv -----
// Top level of the NoC initiator packetizer: CSR block, front end, descriptor
// queue and back end. Depends on npk_pkg, npk_csr, npk_front, npk_queue, npk_back.
//
//   channel   direction  handshake          payload
//   req_*     in         req_valid/ready    command, address, byte_length, peer
//   rsp_*     out        rsp_valid/ready    one flit per transfer
//   csr       in/out     psel/penable/pwrite  paddr, pwdata, prdata (32 bit)
//
// The back end sends one flit per cycle while rsp_ready is high. A request
// makes 1 flit for read, ack, error or short write, F+2 otherwise.
// The front end classifies one request per cycle while the queue has room;
// a request's first flit passes the queue entry and then the output register.
// Reset clears the queue, output register and CSRs, but sets the region bases
// (so no region matches) and the session counter to all ones. rsp_ready low
// holds the current flit; once the queue fills, req_ready drops.
module noc_initiator_packetizer #(
   parameter int BYTES_PER_FLIT = npk_pkg::BYTES_PER_FLIT_DEF,
   parameter int SESSION_SPAN   = npk_pkg::SESSION_SPAN_DEF,
   parameter int REGION_COUNT   = npk_pkg::REGION_COUNT_DEF,
   parameter int QUEUE_DEPTH    = npk_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [npk_pkg::CMD_W-1:0]     req_command,
   input  logic [npk_pkg::ADDR_W-1:0]    req_address,
   input  logic [npk_pkg::LEN_W-1:0]     req_byte_length,
   input  logic [npk_pkg::NODE_W-1:0]    req_peer_node,
   input  logic [npk_pkg::TAG_W-1:0]     req_peer_session,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [npk_pkg::KIND_W-1:0]    rsp_flit_kind,
   output logic [npk_pkg::FLITS_W-1:0]   rsp_flits_remaining,
   output logic [npk_pkg::FLITS_W-1:0]   rsp_packet_flits,
   output logic [npk_pkg::TAG_W-1:0]     rsp_session_tag,
   output logic [npk_pkg::NODE_W-1:0]    rsp_source_node,
   output logic [npk_pkg::NODE_W-1:0]    rsp_target_node,
   output logic                          rsp_last_flit,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [npk_pkg::PADDR_W-1:0]   paddr,
   input  logic [npk_pkg::PDATA_W-1:0]   pwdata,
   output logic [npk_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   npk_pkg::csr_type    csr;
   npk_pkg::desc_type   push_desc;
   npk_pkg::desc_type   pop_desc;
   logic                push, full, pop, empty;

   npk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   npk_front #(
      .BYTES_PER_FLIT (BYTES_PER_FLIT),
      .SESSION_SPAN   (SESSION_SPAN),
      .REGION_COUNT   (REGION_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_byte_length  (req_byte_length),
      .req_peer_node    (req_peer_node),
      .req_peer_session (req_peer_session),
      .full             (full),
      .push             (push),
      .push_desc        (push_desc)
   );

   npk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (full),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .empty     (empty)
   );

   npk_back u_back (
      .clock               (clock),
      .reset               (reset),
      .local_node          (csr.local_node),
      .pop_desc            (pop_desc),
      .empty               (empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_flit_kind       (rsp_flit_kind),
      .rsp_flits_remaining (rsp_flits_remaining),
      .rsp_packet_flits    (rsp_packet_flits),
      .rsp_session_tag     (rsp_session_tag),
      .rsp_source_node     (rsp_source_node),
      .rsp_target_node     (rsp_target_node),
      .rsp_last_flit       (rsp_last_flit)
   );

endmodule
